// ===== rtl/core/swap_mtf_rice_symbol_encoder_core_macros.svh =====
// Assertion macros for the symbol encoder core
`ifndef SWAP_MTF_RICE_SYMBOL_ENCODER_CORE_MACROS_SVH
`define SWAP_MTF_RICE_SYMBOL_ENCODER_CORE_MACROS_SVH
`define SMRE_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("label");
`define SMRE_ASSERT_NXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("label");
`endif

// ===== rtl/core/smre_pkg.sv =====
// ----------------------------------------------------------------------------
// smre_pkg
// Types and constants shared by the symbol encoder core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package smre_pkg;
  localparam logic [1:0] MODE_ENCODE   = 2'd0;
  localparam logic [1:0] MODE_FLUSH    = 2'd1;
  localparam logic [1:0] MODE_IDENTITY = 2'd2;
  localparam logic [1:0] MODE_REVERSE  = 2'd3;
  localparam logic [3:0] RESET_K       = 4'd2;

  typedef struct packed {
    logic       clear_start;
    logic       clear_reverse;
    logic       load_k;
    logic       rd_pos;
    logic       rd_sym;
    logic       swap_wr;
    logic       code_build;
    logic       flush_build;
    logic       emit;
  } smre_cmd_t;

  typedef struct packed {
    logic       clear_done;
    logic       no_move;
    logic [1:0] n_bytes;
    logic       pend_nonzero;
  } smre_sts_t;
endpackage

// ===== rtl/core/smre_if.sv =====
// ----------------------------------------------------------------------------
// smre_if
// Valid/ready channel carrying one item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
interface smre_if #(parameter int W = 8);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/smre_ctrl.sv =====
// ----------------------------------------------------------------------------
// smre_ctrl
// Sequencer for clearing, lookup, swap, coding and byte emission.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module smre_ctrl import smre_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [1:0] in_mode,
  output logic       in_ready,
  input  logic       out_ready,
  output logic       out_valid,
  output logic       out_last,
  output logic [1:0] out_sel,
  input  smre_sts_t  sts,
  output smre_cmd_t  cmd
);
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_POS   = 3'd2;
  localparam logic [2:0] S_SYM   = 3'd3;
  localparam logic [2:0] S_SWAP  = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;

  logic [2:0] state, state_next;
  logic [1:0] idx, idx_next;
  logic [1:0] cnt, cnt_next;
  logic       acc;

  assign in_ready  = (state == S_IDLE);
  assign acc       = in_valid && in_ready;
  assign out_valid = (state == S_EMIT);
  assign out_sel   = idx;
  assign out_last  = (idx + 2'd1 == cnt);

  always_comb begin
    state_next = state;
    idx_next   = idx;
    cnt_next   = cnt;
    cmd        = '0;
    unique case (state)
      S_CLEAR: begin
        if (sts.clear_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (acc) begin
          unique case (in_mode)
            MODE_ENCODE: begin
              cmd.rd_pos = 1'b1;
              state_next = S_POS;
            end
            MODE_FLUSH: begin
              if (sts.pend_nonzero) begin
                cmd.flush_build = 1'b1;
                idx_next   = 2'd0;
                cnt_next   = 2'd1;
                state_next = S_EMIT;
              end
            end
            default: begin
              cmd.clear_start   = 1'b1;
              cmd.clear_reverse = (in_mode == MODE_REVERSE);
              cmd.load_k        = 1'b1;
              state_next        = S_CLEAR;
            end
          endcase
        end
      end
      S_POS: begin
        cmd.rd_sym = 1'b1;
        state_next = S_SYM;
      end
      S_SYM: begin
        state_next = S_SWAP;
      end
      S_SWAP: begin
        cmd.swap_wr    = !sts.no_move;
        cmd.code_build = 1'b1;
        idx_next       = 2'd0;
        cnt_next       = sts.n_bytes;
        state_next     = (sts.n_bytes == 2'd0) ? S_IDLE : S_EMIT;
      end
      S_EMIT: begin
        if (out_ready) begin
          cmd.emit = 1'b1;
          idx_next = idx + 2'd1;
          if (out_last) state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      idx   <= '0;
      cnt   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      cnt   <= cnt_next;
    end
  end
endmodule

// ===== rtl/core/smre_dp.sv =====
// ----------------------------------------------------------------------------
// smre_dp
// Table memories, rotor, Rice coder and bit packer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module smre_dp import smre_pkg::*; #(
  parameter int SWAP_LIMIT = 32,
  parameter int MAX_K      = 15
) (
  input  logic       clk,
  input  logic       rst,
  input  smre_cmd_t  cmd,
  input  logic [7:0] symbol,
  input  logic [3:0] initial_rice_k,
  input  logic [1:0] out_sel,
  output logic [7:0] out_byte,
  output smre_sts_t  sts
);
  localparam logic [3:0] MaxK = 4'(MAX_K);
  localparam logic [8:0] Lim  = 9'(SWAP_LIMIT);

  logic [7:0] sym_at_pos [256];
  logic [7:0] pos_of_sym [256];
  logic [7:0] rotor;
  logic [3:0] rice_k;
  logic [6:0] pend_bits;
  logic [2:0] pend_cnt;

  logic       clearing, clear_rev;
  logic [8:0] clr_ptr;
  logic [7:0] sym_reg, pos_rd, d, pb, sb, sa;
  logic [23:0] bytes;
  logic [1:0]  nb;
  logic        state_sym;

  // clear sweep: one position a cycle
  logic [7:0] cp, cs;
  assign cp = clr_ptr[7:0];
  assign cs = clear_rev ? ~cp : cp;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing  <= 1'b1;
      clear_rev <= 1'b0;
      clr_ptr   <= '0;
    end else if (cmd.clear_start) begin
      clearing  <= 1'b1;
      clear_rev <= cmd.clear_reverse;
      clr_ptr   <= '0;
    end else if (clearing) begin
      clr_ptr <= clr_ptr + 9'd1;
      if (clr_ptr == 9'd255) clearing <= 1'b0;
    end
  end
  assign sts.clear_done = clearing && (clr_ptr == 9'd255);

  // offset and swap targets
  logic [7:0] dd, pa, pbn;
  logic       far;
  assign dd  = pos_rd - rotor;
  assign far = ({1'b0, dd} >= Lim);
  assign pa  = pos_rd;
  assign pbn = far ? rotor - 8'd1 : pos_rd - 8'd1;
  assign sts.no_move = (d == 8'd0);

  // table writes: clear sweep and swap updates of sym_at_pos and pos_of_sym
  always_ff @(posedge clk) begin
    if (clearing) begin
      sym_at_pos[cp] <= cs;
      pos_of_sym[cs] <= cp;
    end else if (cmd.swap_wr) begin
      sym_at_pos[pa]  <= sb;
      sym_at_pos[pb]  <= sa;
    end
    if (!clearing && cmd.swap_wr) begin
      pos_of_sym[sa] <= pb;
      pos_of_sym[sb] <= pa;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_pos) sym_reg <= symbol;
    if (cmd.rd_sym) pos_rd  <= pos_of_sym[sym_reg];
    if (state_sym) begin
      d  <= dd;
      pb <= pbn;
      sb <= sym_at_pos[pbn];
    end
  end
  always_ff @(posedge clk) begin
    if (rst) state_sym <= 1'b0;
    else     state_sym <= cmd.rd_sym;
  end
  assign sa = sym_reg;

  // Rice code
  logic [7:0]  q;
  logic [4:0]  len;
  logic [17:0] code;
  logic [4:0]  knext;
  logic [2:0]  lg;
  always_comb begin
    q     = d >> rice_k;
    code  = '0;
    len   = '0;
    knext = {1'b0, rice_k};
    lg    = '0;
    if (q >= 8'd8) begin
      if (d[7:5] != 3'd0) begin
        code  = {d, 1'b0, 9'h1FF};
        len   = 5'd18;
        knext = {1'b0, rice_k} + 5'd4;
      end else begin
        code  = {4'd0, d[4:0], 1'b0, 8'hFF};
        len   = 5'd14;
        knext = {1'b0, rice_k} + 5'd3;
      end
    end else begin
      code  = (18'((({10'd0, d} & ((18'd1 << rice_k) - 18'd1)) << 1)) << q[2:0])
              | ((18'd1 << q[2:0]) - 18'd1);
      len   = 5'({2'd0, q[2:0]}) + 5'd1 + 5'({1'b0, rice_k});
      if (q[2:0] == 3'd0) begin
        if (rice_k != 4'd0) knext = {1'b0, rice_k} - 5'd1;
      end else begin
        lg    = q[2] ? 3'd2 : (q[1] ? 3'd1 : 3'd0);
        knext = {1'b0, rice_k} + 5'({2'd0, lg});
      end
    end
  end

  logic [24:0] accw;
  logic [4:0]  tot;
  assign accw = {18'd0, pend_bits} | (25'(code) << pend_cnt);
  assign tot  = 5'(len) + 5'({2'd0, pend_cnt});
  assign nb   = tot[4:3];
  assign sts.n_bytes      = nb;
  assign sts.pend_nonzero = (pend_cnt != 3'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      rotor     <= '0;
      rice_k    <= RESET_K;
      pend_bits <= '0;
      pend_cnt  <= '0;
    end else begin
      if (cmd.clear_start) rotor <= '0;
      else if (cmd.swap_wr && far) rotor <= rotor - 8'd1;
      if (cmd.load_k)
        rice_k <= (initial_rice_k > MaxK) ? MaxK : initial_rice_k;
      else if (cmd.code_build)
        rice_k <= (knext > {1'b0, MaxK}) ? MaxK : knext[3:0];
      if (cmd.code_build) begin
        bytes     <= accw[23:0];
        pend_cnt  <= tot[2:0];
        unique case (nb)
          2'd0:    pend_bits <= accw[6:0];
          2'd1:    pend_bits <= accw[14:8];
          2'd2:    pend_bits <= accw[22:16];
          default: pend_bits <= {6'd0, accw[24]};
        endcase
      end else if (cmd.flush_build) begin
        bytes     <= {16'd0, 1'b0, pend_bits & 7'((8'd1 << pend_cnt) - 8'd1)};
        pend_bits <= '0;
        pend_cnt  <= '0;
      end
    end
  end

  always_comb begin
    case (out_sel)
      2'd0:    out_byte = bytes[7:0];
      2'd1:    out_byte = bytes[15:8];
      default: out_byte = bytes[23:16];
    endcase
  end
endmodule

// ===== rtl/core/swap_mtf_rice_symbol_encoder_core.sv =====
// ----------------------------------------------------------------------------
// swap_mtf_rice_symbol_encoder_core
// Move-to-front style byte encoder with adaptive Rice coding.
// ----------------------------------------------------------------------------
// A symbol passes through index lookup, table read, swap and code build before
// its first output byte, then one byte per cycle while the output is ready, up to
// three; a flush emits at most one byte. After reset and after each table
// reset a sweep rewrites both table memories, one entry a cycle.
`timescale 1ns / 1ps
`include "swap_mtf_rice_symbol_encoder_core_macros.svh"
module swap_mtf_rice_symbol_encoder_core import smre_pkg::*; #(
  parameter int SWAP_LIMIT = 32,
  parameter int MAX_K      = 15
) (
  input logic       clk,
  input logic       rst,
  input logic       cfg_we,
  input logic [3:0] cfg_wdata,
  smre_if.sink      in_ch,
  smre_if.source    out_ch
);
  logic [3:0] initial_rice_k;
  smre_cmd_t  cmd;
  smre_sts_t  sts;
  logic [1:0] sel;
  logic       lst;
  logic [7:0] ob;

  always_ff @(posedge clk) begin
    if (rst) initial_rice_k <= RESET_K;
    else if (cfg_we) initial_rice_k <= cfg_wdata;
  end

  smre_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_mode(in_ch.data[9:8]), .in_ready(in_ch.ready),
    .out_ready(out_ch.ready), .out_valid(out_ch.valid), .out_last(lst),
    .out_sel(sel), .sts(sts), .cmd(cmd)
  );

  smre_dp #(.SWAP_LIMIT(SWAP_LIMIT), .MAX_K(MAX_K)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .symbol(in_ch.data[7:0]),
    .initial_rice_k(initial_rice_k), .out_sel(sel), .out_byte(ob), .sts(sts)
  );

  assign out_ch.data = {lst, ob};

  `SMRE_ASSERT_IMP(a_no_in_while_out, clk, rst, out_ch.valid, !in_ch.ready)
  `SMRE_ASSERT_NXT(a_emit_one, clk, rst, cmd.flush_build, out_ch.valid && out_ch.data[8])
  `SMRE_ASSERT_IMP(a_cmd_excl, clk, rst, cmd.code_build, !cmd.flush_build && !cmd.load_k)
endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the move-to-front Rice symbol encoder core: a queue
// of pending items feeds a clocked driver, a local model predicts the packed
// output bytes and a clocked monitor compares them in order, under idling and
// stall patterns on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module testbench;
  import smre_pkg::*;

  localparam int SWAP_LIMIT = 32;
  localparam int MAX_K      = 15;
  localparam int DOG_LIMIT  = 5000;
  localparam int SETTLE     = 300;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] symbol;
  } enc_item_t;

  typedef struct packed {
    logic       last;
    logic [7:0] out_byte;
  } enc_byte_t;

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic [3:0] cfg_wdata;

  smre_if #(.W(10)) in_ch ();
  smre_if #(.W(9))  out_ch ();

  swap_mtf_rice_symbol_encoder_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  enc_item_t pending_items[$];
  enc_byte_t expected_bytes[$];

  logic [7:0] sym_tab[256];
  logic [7:0] pos_tab[256];
  logic [7:0] rotor;
  logic [3:0] rice_k;
  logic [3:0] start_k;
  logic [6:0] pend_bits;
  logic [2:0] pend_cnt;

  int  send_idle_pct;
  int  recv_idle_pct;
  bit  send_hold;
  int  stall_request;
  int  stall_left;
  int  mismatches;
  int  dog;
  bit  failed;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void load_order(bit reverse);
    for (int p = 0; p < 256; p++) begin
      sym_tab[p] = reverse ? 8'(255 - p) : 8'(p);
      pos_tab[sym_tab[p]] = 8'(p);
    end
    rotor  = 8'd0;
    rice_k = start_k;
  endfunction

  function automatic void swap_entries(logic [7:0] a, logic [7:0] b);
    logic [7:0] sa;
    logic [7:0] sb;
    sa = sym_tab[a];
    sb = sym_tab[b];
    sym_tab[a] = sb;
    sym_tab[b] = sa;
    pos_tab[sa] = b;
    pos_tab[sb] = a;
  endfunction

  function automatic void pack_code(logic [31:0] code, int len);
    logic [31:0] acc;
    int          cnt;
    int          n;
    enc_byte_t   b;
    acc = 32'(pend_bits) | (code << pend_cnt);
    cnt = int'(pend_cnt) + len;
    n = 0;
    while (cnt >= 8 && n < 3) begin
      b.out_byte = acc[7:0];
      b.last = (cnt - 8 < 8) || (n == 2);
      expected_bytes.push_back(b);
      acc = acc >> 8;
      cnt -= 8;
      n++;
    end
    pend_bits = acc[6:0];
    pend_cnt  = 3'(cnt);
  endfunction

  function automatic void predict_bytes(enc_item_t it);
    int          d;
    int          k;
    int          q;
    int          ones;
    int          vlen;
    int          j;
    logic [31:0] code;
    enc_byte_t   b;
    case (it.mode)
      MODE_ENCODE: begin
        d = int'(8'(pos_tab[it.symbol] - rotor));
        k = int'(rice_k);
        if (d != 0) begin
          if (d < SWAP_LIMIT) begin
            swap_entries(8'(rotor + d), 8'(rotor + d - 1));
          end else begin
            swap_entries(8'(rotor + d), 8'(rotor - 1));
            rotor = 8'(rotor - 1);
          end
        end
        q = d >> k;
        if (q >= 8) begin
          ones = 8;
          vlen = 5;
          k += 3;
          if ((d >> 5) != 0) begin
            ones = 9;
            vlen = 8;
            k += 1;
          end
          code = ((32'd1 << ones) - 1) | ((32'(d) & ((32'd1 << vlen) - 1)) << (ones + 1));
          pack_code(code, ones + 1 + vlen);
        end else begin
          code = ((32'd1 << q) - 1) | ((32'(d) & ((32'd1 << k) - 1)) << (q + 1));
          pack_code(code, q + 1 + k);
          if (q == 0) begin
            if (k > 0) k--;
          end else begin
            j = q;
            while (j > 1) begin
              k++;
              j = j >> 1;
            end
          end
        end
        rice_k = (k > MAX_K) ? 4'(MAX_K) : 4'(k);
      end
      MODE_FLUSH: begin
        if (pend_cnt != 0) begin
          b.out_byte = 8'(pend_bits & ((7'd1 << pend_cnt) - 1));
          b.last = 1'b1;
          expected_bytes.push_back(b);
          pend_bits = '0;
          pend_cnt  = '0;
        end
      end
      MODE_IDENTITY: load_order(1'b0);
      default:       load_order(1'b1);
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      in_ch.data  <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) predict_bytes(enc_item_t'(in_ch.data));
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_items.size() > 0 && !send_hold &&
            $urandom_range(99) >= send_idle_pct) begin
          in_ch.valid <= 1'b1;
          in_ch.data  <= pending_items.pop_front();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    enc_byte_t got;
    enc_byte_t want;
    if (rst) begin
      out_ch.ready <= 1'b0;
      stall_left   <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = enc_byte_t'(out_ch.data);
        if (expected_bytes.size() == 0) begin
          failed = 1'b1;
          if (mismatches < 10)
            $display("unexpected byte %h last %b", got.out_byte, got.last);
          mismatches++;
        end else begin
          want = expected_bytes.pop_front();
          if (got !== want) begin
            failed = 1'b1;
            if (mismatches < 10)
              $display("byte mismatch: expected %h last %b, got %h last %b",
                       want.out_byte, want.last, got.out_byte, got.last);
            mismatches++;
          end
        end
      end
      if (stall_request > 0) begin
        stall_left    <= stall_request;
        stall_request = 0;
        out_ch.ready  <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left   <= stall_left - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      dog <= 0;
    end else if (dog >= DOG_LIMIT) begin
      $display("[swap_mtf_rice_symbol_encoder_core] ERROR");
      $finish;
    end else begin
      dog <= dog + 1;
    end
  end

  task automatic push_item(logic [1:0] mode, logic [7:0] symbol);
    enc_item_t it;
    it.mode   = mode;
    it.symbol = symbol;
    pending_items.push_back(it);
  endtask

  task automatic wait_drained();
    while (pending_items.size() > 0 || in_ch.valid || expected_bytes.size() > 0)
      @(posedge clk);
  endtask

  task automatic write_start_k(logic [3:0] value);
    wait_drained();
    repeat (SETTLE) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    start_k   = value;
  endtask

  task automatic push_random(int count);
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (r < 72)      push_item(MODE_ENCODE, 8'($urandom));
      else if (r < 86) push_item(MODE_FLUSH, 8'($urandom));
      else if (r < 93) push_item(MODE_IDENTITY, 8'($urandom));
      else             push_item(MODE_REVERSE, 8'($urandom));
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_hold = 1'b0;
    stall_request = 0;
    mismatches = 0;
    failed = 1'b0;
    start_k = RESET_K;
    pend_bits = '0;
    pend_cnt = '0;
    for (int p = 0; p < 256; p++) begin
      sym_tab[p] = 8'(p);
      pos_tab[p] = 8'(p);
    end
    rotor = '0;
    rice_k = RESET_K;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    push_item(MODE_FLUSH, 8'h00);
    push_item(MODE_ENCODE, 8'h00);
    push_item(MODE_ENCODE, 8'h00);
    push_item(MODE_ENCODE, 8'hff);
    push_item(MODE_ENCODE, 8'hff);
    push_item(MODE_ENCODE, 8'd31);
    push_item(MODE_ENCODE, 8'd32);
    push_item(MODE_ENCODE, 8'd1);
    push_item(MODE_FLUSH, 8'hff);
    push_item(MODE_FLUSH, 8'h00);
    push_item(MODE_REVERSE, 8'h00);
    push_item(MODE_ENCODE, 8'h00);
    push_item(MODE_ENCODE, 8'd200);
    push_item(MODE_ENCODE, 8'd255);
    push_item(MODE_IDENTITY, 8'hff);
    push_item(MODE_ENCODE, 8'd8);
    push_item(MODE_ENCODE, 8'd9);
    push_item(MODE_FLUSH, 8'h00);
    wait_drained();

    write_start_k(4'd15);
    push_item(MODE_IDENTITY, 8'h00);
    push_item(MODE_ENCODE, 8'd100);
    push_item(MODE_ENCODE, 8'd3);
    push_item(MODE_FLUSH, 8'h00);
    write_start_k(4'd0);
    push_item(MODE_REVERSE, 8'h00);
    push_item(MODE_ENCODE, 8'd0);
    push_item(MODE_ENCODE, 8'd128);
    push_item(MODE_FLUSH, 8'h00);

    send_idle_pct = 29;
    recv_idle_pct = 70;
    write_start_k(4'd7);
    push_item(MODE_IDENTITY, 8'h00);
    push_random(60);

    write_start_k(4'd0);
    send_idle_pct = 70;
    recv_idle_pct = 29;
    push_item(MODE_IDENTITY, 8'h00);
    push_random(60);

    write_start_k(4'($urandom));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    push_item(MODE_REVERSE, 8'h00);
    push_random(30);
    stall_request = 400;
    wait (pending_items.size() == 0);
    send_hold = 1'b1;
    while (in_ch.valid || expected_bytes.size() > 0) @(posedge clk);
    send_hold = 1'b0;
    push_random(50);
    push_item(MODE_FLUSH, 8'h00);

    wait_drained();
    repeat (SETTLE) @(posedge clk);
    if (!failed && expected_bytes.size() == 0) begin
      $display("[swap_mtf_rice_symbol_encoder_core] OK");
    end else begin
      $display("[swap_mtf_rice_symbol_encoder_core] ERROR");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/smre_pkg.sv
rtl/core/smre_if.sv
rtl/core/smre_ctrl.sv
rtl/core/smre_dp.sv
rtl/core/swap_mtf_rice_symbol_encoder_core.sv
verif/testbench.sv
